// ===== hw/rtl/qpa_pkg.sv =====
`default_nettype none
package qpa_pkg;
    localparam int QW = 16;
    localparam int OW = 17;
    // gravity magnitudes after the shift by 2 fit in 31 bits
    localparam int GW = 32;
    localparam int SW = 64;
    localparam int RW = 32;
    localparam int CW = 34;
    localparam int AW = 36;
    localparam int ATAN_DEPTH = 32;
    localparam longint RAD30_TO_DEG24 = 64'sd961263669;

    typedef logic signed [QW-1:0] t_quat;

    function automatic logic signed [AW-1:0] atan_q30(input logic [4:0] i);
        logic signed [AW-1:0] v;
        case (i)
            5'd0: v = 36'sh03243F6A8;
            5'd1: v = 36'sh01DAC6705;
            5'd2: v = 36'sh00FADBAFC;
            5'd3: v = 36'sh007F56EA6;
            5'd4: v = 36'sh003FEAB76;
            5'd5: v = 36'sh001FFD55B;
            5'd6: v = 36'sh000FFFAAA;
            5'd7: v = 36'sh0007FFF55;
            5'd8: v = 36'sh0003FFFEA;
            5'd9: v = 36'sh0001FFFFD;
            5'd10: v = 36'sh0000FFFFF;
            5'd11: v = 36'sh00007FFFF;
            5'd12: v = 36'sh00003FFFF;
            5'd13: v = 36'sh00001FFFF;
            5'd14: v = 36'sh00000FFFF;
            5'd15: v = 36'sh000007FFF;
            5'd16: v = 36'sh000003FFF;
            5'd17: v = 36'sh000001FFF;
            5'd18: v = 36'sh000000FFF;
            5'd19: v = 36'sh0000007FF;
            5'd20: v = 36'sh0000003FF;
            5'd21: v = 36'sh0000001FF;
            5'd22: v = 36'sh0000000FF;
            5'd23: v = 36'sh00000007F;
            5'd24: v = 36'sh00000003F;
            5'd25: v = 36'sh00000001F;
            5'd26: v = 36'sh00000000F;
            5'd27: v = 36'sh000000007;
            5'd28: v = 36'sh000000003;
            5'd29: v = 36'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/qpa_quat_if.sv =====
`default_nettype none
interface qpa_quat_if;
    import qpa_pkg::*;
    logic  valid;
    logic  ready;
    t_quat quat_w;
    t_quat quat_x;
    t_quat quat_y;
    t_quat quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/qpa_pitch_if.sv =====
`default_nettype none
interface qpa_pitch_if;
    logic        valid;
    logic        ready;
    logic [16:0] pitch_offset_deg;
    modport source (output valid, pitch_offset_deg, input ready);
    modport sink (input valid, pitch_offset_deg, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/qpa_sqrt_cell.sv =====
`default_nettype none
// one restoring square root step: two bits of radicand per cell
module qpa_sqrt_cell #(
    parameter int STEP = 0
) (
    input  wire                   i_clk,
    input  wire                   i_en,
    input  wire [qpa_pkg::SW-1:0] i_rem,
    input  wire [qpa_pkg::SW-1:0] i_res,
    output logic [qpa_pkg::SW-1:0] o_rem,
    output logic [qpa_pkg::SW-1:0] o_res
);
    import qpa_pkg::*;
    localparam logic [SW-1:0] BIT = SW'(1) << (62 - 2 * STEP);
    logic [SW-1:0] n_rem, n_res, trial;
    always_comb begin
        trial = i_res + BIT;
        if (i_rem >= trial) begin
            n_rem = i_rem - trial;
            n_res = (i_res >> 1) + BIT;
        end else begin
            n_rem = i_rem;
            n_res = i_res >> 1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem <= n_rem;
            o_res <= n_res;
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/qpa_cordic_cell.sv =====
`default_nettype none
// one vectoring rotation step
module qpa_cordic_cell #(
    parameter int STEP = 0
) (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire signed [qpa_pkg::CW-1:0] i_x,
    input  wire signed [qpa_pkg::CW-1:0] i_y,
    input  wire signed [qpa_pkg::AW-1:0] i_ang,
    output logic signed [qpa_pkg::CW-1:0] o_x,
    output logic signed [qpa_pkg::CW-1:0] o_y,
    output logic signed [qpa_pkg::AW-1:0] o_ang
);
    import qpa_pkg::*;
    localparam logic signed [AW-1:0] ATAN = atan_q30(5'(STEP));
    logic signed [CW-1:0] dx, dy;
    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_y > 0) begin
                o_x   <= i_x + dx;
                o_y   <= i_y - dy;
                o_ang <= i_ang + ATAN;
            end else begin
                o_x   <= i_x - dx;
                o_y   <= i_y + dy;
                o_ang <= i_ang - ATAN;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/quaternion_to_pitch_angle_core.sv =====
// throughput: one transaction per cycle while the output is taken, the whole chain advances together
// the chain stalls only when the output register is full and not taken
// reset: synchronous active low, clears the valid bits of every stage
// payload registers are not reset
`default_nettype none
module quaternion_to_pitch_angle_core #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int ARCTAN_STAGES   = 16
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    qpa_quat_if.sink    i_quat,
    qpa_pitch_if.source o_pitch
);
    import qpa_pkg::*;

    localparam int SQ = 32;
    localparam int NS = (ARCTAN_STAGES < ATAN_DEPTH) ? ARCTAN_STAGES : ATAN_DEPTH;
    // stages: products, gravity, squares, sum, sqrt cells, cordic cells, mul, out
    localparam int LAT = 4 + SQ + NS + 2;
    localparam int SH  = 54 - ANGLE_FRAC_BITS;
    localparam longint HALF = 64'sd180 <<< ANGLE_FRAC_BITS;

    logic [LAT-1:0] r_vld;
    logic           adv;

    // chain advances whenever the output slot is free or being emptied
    assign adv = !o_pitch.valid || o_pitch.ready;
    assign i_quat.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_quat.valid};
        end
    end

    // stage 1: eight products
    logic signed [31:0] r_xz, r_wy, r_wx, r_yz, r_ww, r_xx, r_yy, r_zz;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xz <= i_quat.quat_x * i_quat.quat_z;
            r_wy <= i_quat.quat_w * i_quat.quat_y;
            r_wx <= i_quat.quat_w * i_quat.quat_x;
            r_yz <= i_quat.quat_y * i_quat.quat_z;
            r_ww <= i_quat.quat_w * i_quat.quat_w;
            r_xx <= i_quat.quat_x * i_quat.quat_x;
            r_yy <= i_quat.quat_y * i_quat.quat_y;
            r_zz <= i_quat.quat_z * i_quat.quat_z;
        end
    end

    // stage 2: gravity vector, magnitudes shifted by two, signs of x and z kept
    logic signed [34:0] gx, gy, gz;
    logic [34:0] mgx, mgy, mgz;
    logic [GW-1:0] r_cy_mag, r_my, r_mz;
    logic r_gx_neg, r_gz_neg;
    always_comb begin
        gx  = 35'sd2 * (35'(r_xz) - 35'(r_wy));
        gy  = 35'sd2 * (35'(r_wx) + 35'(r_yz));
        gz  = 35'(r_ww) - 35'(r_xx) - 35'(r_yy) + 35'(r_zz);
        mgx = gx[34] ? 35'(-gx) : 35'(gx);
        mgy = gy[34] ? 35'(-gy) : 35'(gy);
        mgz = gz[34] ? 35'(-gz) : 35'(gz);
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cy_mag <= mgx[33:2];
            r_my     <= mgy[33:2];
            r_mz     <= mgz[33:2];
            r_gx_neg <= gx[34];
            r_gz_neg <= gz[34];
        end
    end

    // stage 3: squares; stage 4: sum
    logic [SW-1:0] r_sy, r_sz, r_sum;
    logic signed [CW-1:0] r_cy3, r_cy4;
    logic r_gzn3, r_gzn4;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sy   <= SW'(r_my) * SW'(r_my);
            r_sz   <= SW'(r_mz) * SW'(r_mz);
            r_cy3  <= r_gx_neg ? -$signed(CW'(r_cy_mag)) : $signed(CW'(r_cy_mag));
            r_gzn3 <= r_gz_neg;
            r_sum  <= r_sy + r_sz;
            r_cy4  <= r_cy3;
            r_gzn4 <= r_gzn3;
        end
    end

    // square root cells, y and fold flag travel alongside
    logic [SW-1:0] s_rem [SQ+1];
    logic [SW-1:0] s_res [SQ+1];
    logic signed [CW-1:0] s_cy [1:SQ];
    logic s_gzn [1:SQ];
    assign s_rem[0] = r_sum;
    assign s_res[0] = '0;
    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        qpa_sqrt_cell #(.STEP(k)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_rem(s_rem[k]), .i_res(s_res[k]),
            .o_rem(s_rem[k+1]), .o_res(s_res[k+1])
        );
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            s_cy[1]  <= r_cy4;
            s_gzn[1] <= r_gzn4;
            for (int k = 2; k <= SQ; k++) begin
                s_cy[k]  <= s_cy[k-1];
                s_gzn[k] <= s_gzn[k-1];
            end
        end
    end

    // cordic cells; for a zero vector the angle is forced to zero at the multiply
    logic signed [CW-1:0] c_x [NS+1];
    logic signed [CW-1:0] c_y [NS+1];
    logic signed [AW-1:0] c_a [NS+1];
    logic c_gzn [1:NS];
    logic c_zero [1:NS];
    assign c_x[0] = $signed(CW'(s_res[SQ][RW-1:0]));
    assign c_y[0] = s_cy[SQ];
    assign c_a[0] = '0;
    for (genvar k = 0; k < NS; k++) begin : g_cordic
        qpa_cordic_cell #(.STEP(k)) u_cell (
            .i_clk(i_clk), .i_en(adv),
            .i_x(c_x[k]), .i_y(c_y[k]), .i_ang(c_a[k]),
            .o_x(c_x[k+1]), .o_y(c_y[k+1]), .o_ang(c_a[k+1])
        );
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            c_gzn[1]  <= s_gzn[SQ];
            c_zero[1] <= (s_res[SQ] == '0) && (s_cy[SQ] == '0);
            for (int k = 2; k <= NS; k++) begin
                c_gzn[k]  <= c_gzn[k-1];
                c_zero[k] <= c_zero[k-1];
            end
        end
    end

    // degree conversion multiply, then round, fold and clamp
    // the accumulated angle stays below 2^31, so its low 32 bits carry it
    logic signed [63:0] r_prod;
    logic r_gzn_m;
    logic signed [63:0] deg, folded, res;
    logic [OW-1:0] r_out;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod  <= c_zero[NS] ? 64'sd0
                                  : 64'($signed(c_a[NS][31:0])) * RAD30_TO_DEG24;
            r_gzn_m <= c_gzn[NS];
        end
    end
    always_comb begin
        deg = (r_prod + (64'sd1 <<< (SH - 1))) >>> SH;
        if (r_gzn_m) begin
            folded = (deg > 0) ? HALF - deg : -HALF - deg;
        end else begin
            folded = deg;
        end
        res = folded + HALF;
        if (res < 0) begin
            res = 0;
        end
        if (res > 2 * HALF) begin
            res = 2 * HALF;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res[OW-1:0];
        end
    end

    assign o_pitch.valid            = r_vld[LAT-1];
    assign o_pitch.pitch_offset_deg = r_out;
endmodule
`default_nettype wire

// ===== tb/sv/qpa_pitch_checker.sv =====
`default_nettype none
module qpa_pitch_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    qpa_quat_if.sink    i_quat_mon,
    qpa_pitch_if.sink   i_pitch_mon,
    output int          o_fail_count,
    output int          o_pending
);
    import qpa_pkg::*;

    localparam int ANGLE_FRAC = 8;
    localparam int CORDIC_STAGES = 16;

    logic [16:0] pitch_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = pitch_q.size();

    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_floor(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [16:0] predict_pitch(input t_quat qw, input t_quat qx,
                                                  input t_quat qy, input t_quat qz);
        longint w, x, y, z, gx, gy, gz, cx, cy, dx, dy, ang, deg, half, res;
        longint unsigned my, mz;
        longint atan_tab[32];
        int sh;
        atan_tab = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                     64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                     64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                     64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                     64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                     64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                     64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007,
                     64'h00000003, 64'h00000001, 64'h0, 64'h0};
        w = qw; x = qx; y = qy; z = qz;
        gx = 2 * (x * z - w * y);
        gy = 2 * (w * x + y * z);
        gz = w * w - x * x - y * y + z * z;
        my = (gy < 0 ? -gy : gy) >> 2;
        mz = (gz < 0 ? -gz : gz) >> 2;
        cy = (gx < 0 ? -gx : gx) >>> 2;
        if (gx < 0) cy = -cy;
        cx = root_floor(my * my + mz * mz);
        ang = 0;
        // vectoring rotation drives y toward zero
        if (cx != 0 || cy != 0) begin
            for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
                dx = floor_shift(cy, i);
                dy = floor_shift(cx, i);
                if (cy > 0) begin
                    cx += dx; cy -= dy; ang += atan_tab[i];
                end else begin
                    cx -= dx; cy += dy; ang -= atan_tab[i];
                end
            end
        end
        sh   = 54 - ANGLE_FRAC;
        deg  = floor_shift(ang * 64'sd961263669 + (64'sd1 <<< (sh - 1)), sh);
        half = 64'sd180 <<< ANGLE_FRAC;
        // fold past vertical when gravity z points down
        if (gz < 0) deg = (deg > 0) ? half - deg : -half - deg;
        res = deg + half;
        if (res < 0) res = 0;
        if (res > 2 * half) res = 2 * half;
        return res[16:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fails <= 0;
            pitch_q.delete();
        end else begin
            if (i_quat_mon.valid && i_quat_mon.ready)
                pitch_q.push_back(predict_pitch(i_quat_mon.quat_w, i_quat_mon.quat_x,
                                                i_quat_mon.quat_y, i_quat_mon.quat_z));
            if (i_pitch_mon.valid && i_pitch_mon.ready) begin
                if (pitch_q.size() == 0) begin
                    $error("pitch_offset_deg: no transaction expected, got %0d",
                           i_pitch_mon.pitch_offset_deg);
                    fails <= fails + 1;
                end else if (pitch_q[0] !== i_pitch_mon.pitch_offset_deg) begin
                    $error("pitch_offset_deg: expected %0d, actual %0d",
                           pitch_q[0], i_pitch_mon.pitch_offset_deg);
                    fails <= fails + 1;
                    void'(pitch_q.pop_front());
                end else begin
                    void'(pitch_q.pop_front());
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none
module testbench;
    import qpa_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    bit   sink_hold;

    qpa_quat_if  quat_ch ();
    qpa_pitch_if pitch_ch ();

    quaternion_to_pitch_angle_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (quat_ch.sink),
        .o_pitch (pitch_ch.source)
    );

    qpa_pitch_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_quat_mon   (quat_ch.sink),
        .i_pitch_mon  (pitch_ch.sink),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 unit clock period
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // send one quaternion transaction, with an optional random gap first
    task automatic send_quat(input t_quat w, input t_quat x, input t_quat y,
                             input t_quat z, input bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 6) : 0;
        if (gap != 0) begin
            quat_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        quat_ch.valid  <= 1'b1;
        quat_ch.quat_w <= w;
        quat_ch.quat_x <= x;
        quat_ch.quat_y <= y;
        quat_ch.quat_z <= z;
        // wait for the accepting edge, then step to the next falling edge
        do @(posedge i_clk); while (!quat_ch.ready);
        @(negedge i_clk);
    endtask

    // any 16 bit pattern, biased toward the legal unit range
    function automatic t_quat rand_comp();
        case ($urandom_range(0, 9))
            0: return t_quat'($urandom);
            1: return t_quat'(16384);
            2: return t_quat'(-16384);
            3: return t_quat'(0);
            default: return t_quat'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // receiver: random stall per transaction, plus a long hold-off on request
    initial begin
        int stall;
        pitch_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (sink_hold) begin
                pitch_ch.ready <= 1'b0;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                if (stall != 0) begin
                    pitch_ch.ready <= 1'b0;
                    repeat (stall) @(negedge i_clk);
                end
                pitch_ch.ready <= 1'b1;
                // hold ready until one transaction is taken
                do @(posedge i_clk); while (!(pitch_ch.valid && pitch_ch.ready));
            end
        end
    end

    // long receiver stall so the pipeline fills and backs up the input
    initial begin
        sink_hold = 1'b0;
        @(posedge i_rst_n);
        repeat (300) @(negedge i_clk);
        sink_hold = 1'b1;
        repeat (200) @(negedge i_clk);
        sink_hold = 1'b0;
    end

    initial begin
        int n;
        i_rst_n         = 1'b0;
        quat_ch.valid   = 1'b0;
        quat_ch.quat_w  = '0;
        quat_ch.quat_x  = '0;
        quat_ch.quat_y  = '0;
        quat_ch.quat_z  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero quaternion, axis rotations, extremes, raw bit patterns
        send_quat(0, 0, 0, 0, 0);
        send_quat(16384, 0, 0, 0, 0);
        send_quat(0, 16384, 0, 0, 0);
        send_quat(0, 0, 16384, 0, 0);
        send_quat(0, 0, 0, 16384, 0);
        send_quat(-16384, 0, 0, 0, 1);
        send_quat(0, -16384, 0, 0, 1);
        send_quat(0, 0, -16384, 0, 1);
        send_quat(0, 0, 0, -16384, 1);
        send_quat(11585, 0, 11585, 0, 1);
        send_quat(11585, 0, -11585, 0, 1);
        send_quat(16384, 16384, 16384, 16384, 1);
        send_quat(-16384, 16384, -16384, 16384, 1);
        send_quat(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1);
        send_quat(-16'sh8000, -16'sh8000, -16'sh8000, -16'sh8000, 1);
        send_quat(-16'sh8000, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 1);
        send_quat(16'sh5555, -16'sh5556, 16'sh2AAA, 16'sh1234, 1);
        send_quat(0, 16384, 0, 1, 1);
        send_quat(0, 11585, 0, 11585, 1);
        send_quat(1, 0, 0, 0, 0);

        // random with bursts of back to back transactions
        for (n = 0; n < 2000; n++)
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                      ($urandom_range(0, 3) != 0) && (n % 200 > 40));
        quat_ch.valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("[quaternion_to_pitch_angle_core] OK");
        else
            $display("[quaternion_to_pitch_angle_core] ERROR");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("[quaternion_to_pitch_angle_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ===== quaternion_to_pitch_angle_core.f =====
hw/rtl/qpa_pkg.sv
hw/rtl/qpa_quat_if.sv
hw/rtl/qpa_pitch_if.sv
hw/rtl/qpa_sqrt_cell.sv
hw/rtl/qpa_cordic_cell.sv
hw/rtl/quaternion_to_pitch_angle_core.sv
tb/sv/qpa_pitch_checker.sv
tb/sv/testbench.sv
